// ----- hw/rtl/pcd_pkg.sv -----
// ----------------------------------------------------------------------------
// pcd_pkg
// shared types and codes for the png chunk deframer
// ----------------------------------------------------------------------------
package pcd_pkg;

  // kind of an accepted request
  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_EOF  = 1'b1
  } kind_t;

  // status codes on the result side
  typedef enum logic [2:0] {
    ST_RUN    = 3'd0,
    ST_DONE   = 3'd1,
    ST_BADSIG = 3'd2,
    ST_EOF    = 3'd3,
    ST_BADCRC = 3'd4
  } status_t;

  // one classified request waiting between front and back
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } entry_t;

  // one result item
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        chunk_end;
    logic [31:0] chunk_id;
    status_t     status;
  } result_t;

endpackage

// ----- hw/rtl/pcd_front.sv -----
// ----------------------------------------------------------------------------
// pcd_front
// accepts requests, classifies them and queues them for the parser
// ----------------------------------------------------------------------------
module pcd_front #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic            cmd,
  input  logic [7:0]      data_byte,
  output logic            q_valid,
  output pcd_pkg::entry_t q_entry,
  input  logic            q_take
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  pcd_pkg::entry_t    slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               do_push;
  logic               do_take;
  pcd_pkg::entry_t    incoming;

  assign full    = (count == COUNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_take = q_take && q_valid;

  always_comb begin
    incoming.kind = cmd ? pcd_pkg::KIND_EOF : pcd_pkg::KIND_BYTE;
    incoming.data = data_byte;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_take) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_take) begin
        count <= count + 1'b1;
      end else if (!do_push && do_take) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/pcd_back.sv -----
// ----------------------------------------------------------------------------
// pcd_back
// chunk parser with byte-wide crc-32 and a two-entry result queue
// ----------------------------------------------------------------------------
module pcd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  pcd_pkg::entry_t  q_entry,
  output logic             q_take,
  output logic             empty,
  input  logic             pop,
  output pcd_pkg::result_t res
);

  typedef enum logic [5:0] {
    PH_SIG  = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_TYPE = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CRC  = 6'b010000,
    PH_STOP = 6'b100000
  } phase_t;

  localparam logic [63:0] SIGNATURE = 64'h89504E470D0A1A0A;
  localparam logic [31:0] IEND_TYPE = 32'h49454E44;
  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  phase_t            phase,            phase_next;
  logic [2:0]        field_byte_count, field_byte_count_next;
  logic              signature_mismatch, signature_mismatch_next;
  logic [31:0]       data_remaining,   data_remaining_next;
  logic [31:0]       type_shift,       type_shift_next;
  logic [31:0]       crc_running,      crc_running_next;
  logic [31:0]       crc_stored_shift, crc_stored_shift_next;
  pcd_pkg::status_t  sticky_status,    sticky_status_next;
  pcd_pkg::result_t  result;

  logic [7:0]        b;
  logic [7:0]        sig_byte;
  logic [31:0]       crc_stored_full;
  logic [31:0]       crc_updated;

  // result queue
  pcd_pkg::result_t  out_slots [2];
  logic              out_wr;
  logic              out_rd;
  logic [1:0]        out_count;
  logic              out_full;
  logic              do_pop;

  assign out_full = (out_count == 2'd2);
  assign empty    = (out_count == 2'd0);
  assign do_pop   = pop && !empty;
  assign q_take   = q_valid && (!out_full || do_pop);
  assign res      = out_slots[out_rd];

  assign b               = q_entry.data;
  assign sig_byte        = SIGNATURE[8*(7 - field_byte_count) +: 8];
  assign crc_stored_full = {crc_stored_shift[23:0], b};
  assign crc_updated     = crc_byte(crc_running, b);

  always_comb begin
    phase_next              = phase;
    field_byte_count_next   = field_byte_count;
    signature_mismatch_next = signature_mismatch;
    data_remaining_next     = data_remaining;
    type_shift_next         = type_shift;
    crc_running_next        = crc_running;
    crc_stored_shift_next   = crc_stored_shift;
    sticky_status_next      = sticky_status;
    result                  = '0;

    if (phase == PH_STOP) begin
      // ignored after a stop
    end else if (q_entry.kind == pcd_pkg::KIND_EOF) begin
      sticky_status_next = pcd_pkg::ST_EOF;
      phase_next         = PH_STOP;
    end else begin
      unique case (phase)
        PH_SIG: begin
          signature_mismatch_next = signature_mismatch || (b != sig_byte);
          field_byte_count_next   = field_byte_count + 3'd1;
          if (field_byte_count == 3'd7) begin
            field_byte_count_next = '0;
            if (signature_mismatch_next) begin
              sticky_status_next = pcd_pkg::ST_BADSIG;
              phase_next         = PH_STOP;
            end else begin
              phase_next      = PH_LEN;
              type_shift_next = '0;
            end
          end
        end
        PH_LEN: begin
          type_shift_next       = {type_shift[23:0], b};
          field_byte_count_next = field_byte_count + 3'd1;
          if (field_byte_count == 3'd3) begin
            data_remaining_next   = {type_shift[23:0], b};
            type_shift_next       = '0;
            field_byte_count_next = '0;
            crc_running_next      = '1;
            phase_next            = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_shift_next       = {type_shift[23:0], b};
          crc_running_next      = crc_updated;
          field_byte_count_next = field_byte_count + 3'd1;
          if (field_byte_count == 3'd3) begin
            field_byte_count_next = '0;
            crc_stored_shift_next = '0;
            phase_next            = (data_remaining == '0) ? PH_CRC : PH_DATA;
          end
        end
        PH_DATA: begin
          result.payload_valid = 1'b1;
          result.payload_byte  = b;
          crc_running_next     = crc_updated;
          data_remaining_next  = data_remaining - 32'd1;
          if (data_remaining == 32'd1) begin
            crc_stored_shift_next = '0;
            field_byte_count_next = '0;
            phase_next            = PH_CRC;
          end
        end
        PH_CRC: begin
          crc_stored_shift_next = crc_stored_full;
          field_byte_count_next = field_byte_count + 3'd1;
          if (field_byte_count == 3'd3) begin
            field_byte_count_next = '0;
            if (crc_stored_full != ~crc_running) begin
              sticky_status_next = pcd_pkg::ST_BADCRC;
              phase_next         = PH_STOP;
            end else begin
              result.chunk_end = 1'b1;
              result.chunk_id  = type_shift;
              if (type_shift == IEND_TYPE) begin
                sticky_status_next = pcd_pkg::ST_DONE;
                phase_next         = PH_STOP;
              end else begin
                type_shift_next = '0;
                phase_next      = PH_LEN;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    result.status = sticky_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_SIG;
      field_byte_count   <= '0;
      signature_mismatch <= 1'b0;
      data_remaining     <= '0;
      type_shift         <= '0;
      crc_running        <= '1;
      crc_stored_shift   <= '0;
      sticky_status      <= pcd_pkg::ST_RUN;
    end else if (q_take) begin
      phase              <= phase_next;
      field_byte_count   <= field_byte_count_next;
      signature_mismatch <= signature_mismatch_next;
      data_remaining     <= data_remaining_next;
      type_shift         <= type_shift_next;
      crc_running        <= crc_running_next;
      crc_stored_shift   <= crc_stored_shift_next;
      sticky_status      <= sticky_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      out_slots[out_wr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr    <= 1'b0;
      out_rd    <= 1'b0;
      out_count <= '0;
    end else begin
      if (q_take) begin
        out_wr <= ~out_wr;
      end
      if (do_pop) begin
        out_rd <= ~out_rd;
      end
      if (q_take && !do_pop) begin
        out_count <= out_count + 2'd1;
      end else if (!q_take && do_pop) begin
        out_count <= out_count - 2'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/png_chunk_deframer_top.sv -----
// ----------------------------------------------------------------------------
// png_chunk_deframer_top
// png signature check, chunk framing, payload pass-through and crc-32 check
// ----------------------------------------------------------------------------
//  channel   handshake        fields
//  input     push / full      cmd, data_byte
//  result    empty / pop      payload_valid, payload_byte, chunk_end,
//                             chunk_id, status
//
//  one result per request; the parser retires one request per cycle while
//  the result queue has room or is being popped, so a request can follow
//  in every cycle; each request is registered in the front queue, then
//  its result in the result queue, before it can be popped.
//  the front queue holds QUEUE_DEPTH requests, the result queue two; with
//  pop held low the block keeps taking requests until both are full.
//  rst is synchronous and clears the parser to the signature phase and
//  both queues to empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module png_chunk_deframer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic        payload_valid,
  output logic [7:0]  payload_byte,
  output logic        chunk_end,
  output logic [31:0] chunk_id,
  output logic [2:0]  status
);

  logic             q_valid;
  logic             q_take;
  pcd_pkg::entry_t  q_entry;
  pcd_pkg::result_t res;

  pcd_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .data_byte (data_byte),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_take    (q_take)
  );

  pcd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_take  (q_take),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  assign payload_valid = res.payload_valid;
  assign payload_byte  = res.payload_byte;
  assign chunk_end     = res.chunk_end;
  assign chunk_id      = res.chunk_id;
  assign status        = res.status;

endmodule

// ----- verif/png_chunk_deframer_top_test.sv -----
// ----------------------------------------------------------------------------
// png_chunk_deframer_top_test
// self-checking bench for the png chunk deframer: builds one png byte
// stream (signature, chunks with correct or broken crc, a random way to
// end), predicts every result in a behavioral deframer and compares each
// popped result field by field, with random push gaps and pop stalls
// ----------------------------------------------------------------------------
module png_chunk_deframer_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] PNG_SIGNATURE   = 64'h89504E470D0A1A0A;
  localparam logic [31:0] IEND_TYPE       = 32'h49454E44;
  localparam int          RANDOM_REQUESTS = 800;
  localparam int          TARGET_REQUESTS = 850;
  localparam int          HOLD_CYCLES     = 64;
  localparam int          DRAIN_CYCLES    = 12;
  localparam int          STALL_LIMIT     = 2000;

  typedef enum logic [2:0] {
    P_SIGNATURE, P_LENGTH, P_TYPE, P_DATA, P_CRC, P_STOPPED
  } parse_phase_t;

  typedef enum int {
    END_IEND, END_IEND_BAD_CRC, END_BAD_CRC, END_EOF_BOUNDARY, END_EOF_LENGTH,
    END_EOF_TYPE, END_EOF_DATA, END_EOF_CRC, END_EOF_HUGE
  } stream_end_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        cmd = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        chunk_end;
  logic [31:0] chunk_id;
  logic [2:0]  status;

  png_chunk_deframer_top dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .cmd           (cmd),
    .data_byte     (data_byte),
    .empty         (empty),
    .pop           (pop),
    .payload_valid (payload_valid),
    .payload_byte  (payload_byte),
    .chunk_end     (chunk_end),
    .chunk_id      (chunk_id),
    .status        (status)
  );

  always #4 clk = ~clk;

  // behavioral deframer state
  parse_phase_t       m_phase = P_SIGNATURE;
  int                 m_count = 0;
  logic               m_sig_bad = 1'b0;
  logic [31:0]        m_left = '0;
  logic [31:0]        m_shift = '0;
  logic [31:0]        m_crc = '1;
  logic [31:0]        m_crc_stored = '0;
  pcd_pkg::status_t   m_status = pcd_pkg::ST_RUN;

  pcd_pkg::result_t   deframe_results[$];
  logic [7:0]         preset_payload[$];
  int                 requests_sent = 0;
  int                 error_count = 0;
  int                 send_idle_pct = 0;
  int                 pop_stall_pct = 0;
  int                 hold_asks = 0;
  int                 hold_seen = 0;
  int                 hold_left = 0;

  function automatic logic [31:0] crc32_update(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void stop_parse(pcd_pkg::status_t st);
    m_status = st;
    m_phase = P_STOPPED;
  endfunction

  function automatic pcd_pkg::result_t deframe_step(pcd_pkg::kind_t kind, logic [7:0] b);
    pcd_pkg::result_t r;
    r = '0;
    if (m_status != pcd_pkg::ST_RUN || m_phase == P_STOPPED) begin
      // ignored once stopped
    end else if (kind == pcd_pkg::KIND_EOF) begin
      stop_parse(pcd_pkg::ST_EOF);
    end else begin
      case (m_phase)
        P_SIGNATURE: begin
          if (b != PNG_SIGNATURE[63 - 8 * m_count -: 8]) m_sig_bad = 1'b1;
          m_count++;
          if (m_count >= 8) begin
            m_count = 0;
            if (m_sig_bad) stop_parse(pcd_pkg::ST_BADSIG);
            else begin
              m_phase = P_LENGTH;
              m_shift = '0;
            end
          end
        end
        P_LENGTH: begin
          m_shift = {m_shift[23:0], b};
          m_count++;
          if (m_count >= 4) begin
            m_left = m_shift;
            m_shift = '0;
            m_count = 0;
            m_crc = '1;
            m_phase = P_TYPE;
          end
        end
        P_TYPE: begin
          m_shift = {m_shift[23:0], b};
          m_crc = crc32_update(m_crc, b);
          m_count++;
          if (m_count >= 4) begin
            m_count = 0;
            m_crc_stored = '0;
            m_phase = (m_left == 0) ? P_CRC : P_DATA;
          end
        end
        P_DATA: begin
          r.payload_valid = 1'b1;
          r.payload_byte = b;
          m_crc = crc32_update(m_crc, b);
          m_left--;
          if (m_left == 0) begin
            m_crc_stored = '0;
            m_count = 0;
            m_phase = P_CRC;
          end
        end
        P_CRC: begin
          m_crc_stored = {m_crc_stored[23:0], b};
          m_count++;
          if (m_count >= 4) begin
            m_count = 0;
            if (m_crc_stored != ~m_crc) stop_parse(pcd_pkg::ST_BADCRC);
            else begin
              r.chunk_end = 1'b1;
              r.chunk_id = m_shift;
              if (m_shift == IEND_TYPE) stop_parse(pcd_pkg::ST_DONE);
              else begin
                m_shift = '0;
                m_phase = P_LENGTH;
              end
            end
          end
        end
        default: ;
      endcase
    end
    r.status = m_status;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // one request: random gap, then hold push until the block takes it
  task automatic send_request(pcd_pkg::kind_t kind, logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    cmd = kind;
    data_byte = b;
    do @(posedge clk); while (full);
    deframe_results.push_back(deframe_step(kind, b));
    requests_sent++;
  endtask

  // one chunk; crc_flip corrupts the stored crc, cut_at ends input at that byte
  task automatic send_chunk(logic [31:0] len_field, logic [31:0] ctype,
                            logic [31:0] crc_flip, longint cut_at);
    longint      total;
    logic [31:0] crc;
    logic [7:0]  b;
    total = 64'd12 + len_field;
    crc = '1;
    for (longint i = 0; i < total && i != cut_at; i++) begin
      if (i < 4) b = 8'(len_field >> (8 * (3 - i)));
      else if (i < 8) begin
        b = 8'(ctype >> (8 * (7 - i)));
        crc = crc32_update(crc, b);
      end else if (i < total - 4) begin
        b = (preset_payload.size() != 0) ? preset_payload.pop_front() : 8'($urandom);
        crc = crc32_update(crc, b);
      end else b = 8'((~crc ^ crc_flip) >> (8 * (total - 1 - i)));
      send_request(pcd_pkg::KIND_BYTE, b);
    end
    if (cut_at >= 0) send_request(pcd_pkg::KIND_EOF, 8'($urandom));
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
      1: begin send_idle_pct = 51; pop_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  pop_stall_pct = 51; end
      default: begin send_idle_pct = 35; pop_stall_pct = 35; end
    endcase
  endtask

  // mostly a clean signature; now and then a wrong byte or an early end
  task automatic test_signature();
    int         roll;
    int         bad_at;
    int         cut_at;
    logic [7:0] b;
    roll = $urandom_range(0, 19);
    bad_at = (roll == 0) ? $urandom_range(0, 7) : -1;
    cut_at = (roll == 1) ? $urandom_range(0, 7) : -1;
    for (int i = 0; i < 8 && i != cut_at; i++) begin
      b = PNG_SIGNATURE[63 - 8 * i -: 8];
      if (i == bad_at) b ^= 8'($urandom_range(1, 255));
      send_request(pcd_pkg::KIND_BYTE, b);
    end
    if (cut_at >= 0) send_request(pcd_pkg::KIND_EOF, 8'($urandom));
  endtask

  task automatic test_directed_chunks();
    send_chunk(32'h0, 32'hFFFFFFFF, 32'h0, -1);
    preset_payload = '{8'h00, 8'hFF};
    send_chunk(32'h2, 32'h0, 32'h0, -1);
  endtask

  task automatic test_random_chunks();
    int          first;
    int          len;
    logic [31:0] ctype;
    bit          pressed;
    first = requests_sent;
    pressed = 1'b0;
    while (requests_sent - first < RANDOM_REQUESTS) begin
      set_idling((requests_sent - first) * 4 / RANDOM_REQUESTS);
      // long pop hold-off while the sender keeps pushing
      if (!pressed && requests_sent - first > 40) begin
        hold_asks++;
        pressed = 1'b1;
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 90) : $urandom_range(0, 24);
      ctype = $urandom;
      if (ctype == IEND_TYPE) ctype ^= 32'h1;
      send_chunk(len, ctype, 32'h0, -1);
    end
  endtask

  task automatic test_stream_end();
    stream_end_t pick;
    int          len;
    logic [31:0] ctype;
    logic [31:0] flip;
    pick = stream_end_t'($urandom_range(0, 8));
    len = $urandom_range(0, 6);
    ctype = $urandom;
    flip = $urandom;
    if (flip == 0) flip = 32'h1;
    case (pick)
      END_IEND:         send_chunk(len, IEND_TYPE, 32'h0, -1);
      END_IEND_BAD_CRC: send_chunk(len, IEND_TYPE, flip, -1);
      END_BAD_CRC:      send_chunk(len, ctype, flip, -1);
      END_EOF_BOUNDARY: send_chunk(len, ctype, 32'h0, 0);
      END_EOF_LENGTH:   send_chunk(len, ctype, 32'h0, $urandom_range(1, 3));
      END_EOF_TYPE:     send_chunk(len, ctype, 32'h0, $urandom_range(4, 7));
      END_EOF_DATA: begin
        len = $urandom_range(2, 6);
        send_chunk(len, ctype, 32'h0, 8 + $urandom_range(1, len - 1));
      end
      END_EOF_CRC:      send_chunk(len, ctype, 32'h0, 8 + len + $urandom_range(0, 3));
      default: begin
        // length far beyond the stream, cut off inside the payload
        send_chunk(($urandom_range(0, 1) != 0) ? 32'hFFFFFFFF : ($urandom | 32'h80000000),
                   ctype, 32'h0, 12 + $urandom_range(0, 20));
      end
    endcase
  endtask

  // ignored requests; an early stop is padded out to the full request count
  task automatic test_after_stop();
    int n;
    n = (requests_sent + 16 < TARGET_REQUESTS) ? TARGET_REQUESTS - requests_sent : 16;
    repeat (n) send_request(pcd_pkg::kind_t'($urandom_range(0, 1)), 8'($urandom));
  endtask

  // pop side: random stalls plus one long hold-off when asked
  always @(negedge clk) begin
    if (rst) pop = 1'b0;
    else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
      pop = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop = 1'b0;
    end else pop = ($urandom_range(0, 99) >= pop_stall_pct);
  end

  always @(posedge clk) begin : result_check
    pcd_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (deframe_results.size() == 0) report_mismatch("result with no request pending", 0, 0);
      else begin
        want = deframe_results.pop_front();
        if (payload_valid !== want.payload_valid)
          report_mismatch("payload_valid", payload_valid, want.payload_valid);
        if (payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", payload_byte, want.payload_byte);
        if (chunk_end !== want.chunk_end)
          report_mismatch("chunk_end", chunk_end, want.chunk_end);
        if (chunk_id !== want.chunk_id)
          report_mismatch("chunk_id", chunk_id, want.chunk_id);
        if (status !== want.status)
          report_mismatch("status", status, want.status);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_signature();
    if (m_status == pcd_pkg::ST_RUN) begin
      test_directed_chunks();
      test_random_chunks();
      test_stream_end();
    end
    test_after_stop();
    @(negedge clk);
    push = 1'b0;
    while (deframe_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
